>>> hdl/complex_matrix_row_op_engine_defines.svh
// Assertion macros for the complex matrix row operation engine.
`ifndef COMPLEX_MATRIX_ROW_OP_ENGINE_DEFINES_SVH
`define COMPLEX_MATRIX_ROW_OP_ENGINE_DEFINES_SVH
`ifndef ASSERT_OFF
`define CMROE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CMROE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CMROE_ASSERT(lbl, clk, rst, prop, msg)
`define CMROE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> hdl/cmroe_pkg.sv
// Shared codes, types and saturation helpers of the complex matrix row op engine.
package cmroe_pkg;

   localparam logic [4:0] OP_ZERO     = 5'd0;
   localparam logic [4:0] OP_UNIT     = 5'd1;
   localparam logic [4:0] OP_SETBUF   = 5'd2;
   localparam logic [4:0] OP_READBUF  = 5'd3;
   localparam logic [4:0] OP_LOAD     = 5'd4;
   localparam logic [4:0] OP_STORE    = 5'd5;
   localparam logic [4:0] OP_SWAP     = 5'd6;
   localparam logic [4:0] OP_MUL      = 5'd7;
   localparam logic [4:0] OP_ADD      = 5'd8;
   localparam logic [4:0] OP_NEG      = 5'd9;
   localparam logic [4:0] OP_INV      = 5'd10;
   localparam logic [4:0] OP_MAXABS   = 5'd11;
   localparam logic [4:0] OP_ISUNIT   = 5'd12;
   localparam logic [4:0] OP_ISZERO   = 5'd13;
   localparam logic [4:0] OP_SWAPROWS = 5'd14;
   localparam logic [4:0] OP_SCALEROW = 5'd15;
   localparam logic [4:0] OP_ADDROWMUL = 5'd16;

   localparam logic [1:0] ERR_OK    = 2'd0;
   localparam logic [1:0] ERR_RANGE = 2'd1;
   localparam logic [1:0] ERR_DIV0  = 2'd2;

   localparam logic REG_ROWS = 1'b0;
   localparam logic REG_COLS = 1'b1;

   localparam logic [31:0] Q_ONE   = 32'h0001_0000;
   localparam logic [31:0] Q_MAX   = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_MIN   = 32'h8000_0000;
   localparam int          QUO_W   = 34;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_DECODE, ST_ELEM, ST_CMUL, ST_CMUL_END,
      ST_MAG_E, ST_MAG_B, ST_MAG_END, ST_DIV_RE, ST_DIV_IM,
      ST_ROW_RD, ST_ROW_CAP, ST_ROW_RD2, ST_ROW_CAP2, ST_ROW_WR,
      ST_SW_RDA, ST_SW_RDB, ST_SW_WR1, ST_SW_WR2, ST_DONE
   } state_type;

   typedef struct packed {
      logic en;
      logic clr;
      logic sub;
   } mul_ctrl_type;

   typedef struct packed {
      logic        sat;
      logic [31:0] val;
   } clamp_type;

   // round to nearest (ties up) after >>16, then clamp to 32 bits
   function automatic clamp_type rnd_clamp(input logic signed [65:0] x);
      logic signed [65:0] t;
      logic signed [49:0] s;
      clamp_type          r;
      t = x + 66'sd32768;
      s = t[65:16];
      if (s > 50'sd2147483647) r = '{1'b1, Q_MAX};
      else if (s < -50'sd2147483648) r = '{1'b1, Q_MIN};
      else r = '{1'b0, s[31:0]};
      return r;
   endfunction

   function automatic clamp_type add_clamp(input logic signed [31:0] a,
                                           input logic signed [31:0] b);
      logic signed [32:0] s;
      clamp_type          r;
      s = 33'(a) + 33'(b);
      if (s[32] != s[31]) r = '{1'b1, (s[32] ? Q_MIN : Q_MAX)};
      else r = '{1'b0, s[31:0]};
      return r;
   endfunction

   function automatic clamp_type neg_clamp(input logic signed [31:0] a);
      clamp_type r;
      if (a == $signed(Q_MIN)) r = '{1'b1, Q_MAX};
      else r = '{1'b0, 32'(-a)};
      return r;
   endfunction

   // apply sign to an unsigned quotient and clamp
   function automatic clamp_type div_fix(input logic [QUO_W-1:0] q, input logic neg);
      clamp_type r;
      if (neg) begin
         if (q > QUO_W'(Q_MIN)) r = '{1'b1, Q_MIN};
         else r = '{1'b0, 32'(-q)};
      end else begin
         if (q > QUO_W'(Q_MAX)) r = '{1'b1, Q_MAX};
         else r = '{1'b0, q[31:0]};
      end
      return r;
   endfunction

endpackage

>>> hdl/complex_matrix_row_op_engine.sv
// Top level of the complex matrix row operation engine: sequencer and state.
//
// The engine holds a MAX_ROWS x MAX_COLS matrix of complex Q16.16 values in a
// RAM and one complex buffer register. Each request beat carries one op and
// gives exactly one response beat with the buffer after the op and status.
// One request is worked at a time; req_tready is high only while the engine
// is idle, and a finished response waits in an output register so the next
// request can be taken meanwhile. All products go through one shared 32x32
// multiply-accumulate unit and inversion uses a one-bit-per-cycle divider
// that gives 34 quotient bits per part. After reset a clearing pass writes
// zero to all MAX_ROWS*MAX_COLS entries, one per cycle, before the first
// request is taken; configuration writes are taken at any time.
module complex_matrix_row_op_engine
   import cmroe_pkg::*;
#(
   parameter int MAX_ROWS = 8,
   parameter int MAX_COLS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // request beat
   input  logic        req_tvalid,
   output logic        req_tready,
   // fields from bit 0: row[2:0], col[5:3], src_row[8:6], value_re[40:9],
   // value_im[72:41], zero pad
   input  logic [79:0] req_tdata,
   // fields from bit 0: op[4:0]
   input  logic [4:0]  req_tuser,
   // response beat
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // fields from bit 0: buffer_re[31:0], buffer_im[63:32], flag[64],
   // error[66:65], saturated[67], zero pad
   output logic [71:0] rsp_tdata,
   // register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [3:0]  csr_data
);

`include "complex_matrix_row_op_engine_defines.svh"

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(MAX_COLS + 1);

   state_type          state_ff, state_in;
   logic [3:0]         rows_ff, rows_in;
   logic [3:0]         cols_ff, cols_in;
   logic [4:0]         op_ff, op_in;
   logic [2:0]         row_ff, row_in;
   logic [2:0]         col_ff, col_in;
   logic [2:0]         srow_ff, srow_in;
   logic signed [31:0] vre_ff, vre_in, vim_ff, vim_in;
   logic signed [31:0] buf_re_ff, buf_re_in, buf_im_ff, buf_im_in;
   logic signed [31:0] elem_re_ff, elem_re_in, elem_im_ff, elem_im_in;
   logic signed [31:0] res_re_ff, res_re_in, res_im_ff, res_im_in;
   logic [63:0]        mag_ff, mag_in;
   logic               flag_ff, flag_in;
   logic [1:0]         err_ff, err_in;
   logic               sat_ff, sat_in;
   logic [1:0]         step_ff, step_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [71:0]        rsp_data_ff, rsp_data_in;
   logic               rsp_load;

   logic [3:0]         nr, nc;
   logic               req_accept;
   logic               elem_op;
   logic               last_row_col, last_swap_col, acc_zero;
   logic [AW-1:0]      ea, ra_c, sa_c;

   // RAM, multiplier and divider hookups
   logic               ram_we, ram_re;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   logic [63:0]        ram_wdata, ram_rdata;
   logic signed [31:0] rd_re, rd_im;
   mul_ctrl_type       mul_ctrl;
   logic signed [31:0] mul_a, mul_b;
   logic signed [65:0] acc;
   logic               div_start, div_done;
   logic [31:0]        div_num;
   logic [63:0]        div_den;
   logic [QUO_W-1:0]   div_quo;
   clamp_type          c_re, c_im;

   cmroe_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   cmroe_mul u_mul (
      .clock (clock),
      .ctrl  (mul_ctrl),
      .a     (mul_a),
      .b     (mul_b),
      .acc   (acc)
   );

   cmroe_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // registers above the matrix size act as the matrix size
   assign nr = (32'(rows_ff) > MAX_ROWS) ? 4'(MAX_ROWS) : rows_ff;
   assign nc = (32'(cols_ff) > MAX_COLS) ? 4'(MAX_COLS) : cols_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign rd_re = ram_rdata[63:32];
   assign rd_im = ram_rdata[31:0];

   assign ea   = AW'(32'(row_ff) * MAX_COLS + 32'(col_ff));
   assign ra_c = AW'(32'(row_ff) * MAX_COLS + 32'(cnt_ff));
   assign sa_c = AW'(32'(srow_ff) * MAX_COLS + 32'(cnt_ff));

   assign last_row_col  = (32'(cnt_ff) + 1) == 32'(nc);
   assign last_swap_col = 32'(cnt_ff) == (MAX_COLS - 1);
   assign acc_zero      = (acc == 66'sd0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:    if (32'(clr_ff) == DEPTH - 1) state_in = ST_IDLE;
         ST_IDLE:     if (req_accept) state_in = ST_DECODE;
         ST_DECODE: begin
            if (err_ff != ERR_OK) state_in = ST_DONE;
            else if (op_ff inside {[OP_LOAD:OP_ADD], [OP_MAXABS:OP_ISZERO]})
               state_in = ST_ELEM;
            else if (op_ff == OP_INV) state_in = ST_MAG_B;
            else if (op_ff == OP_SWAPROWS) state_in = ST_SW_RDA;
            else if (op_ff inside {OP_SCALEROW, OP_ADDROWMUL})
               state_in = (nc == 4'd0) ? ST_DONE : ST_ROW_RD;
            else state_in = ST_DONE;
         end
         ST_ELEM: begin
            if (op_ff == OP_MUL) state_in = ST_CMUL;
            else if (op_ff == OP_MAXABS) state_in = ST_MAG_E;
            else state_in = ST_DONE;
         end
         ST_CMUL:     if (step_ff == 2'd3) state_in = ST_CMUL_END;
         ST_CMUL_END: begin
            if (op_ff == OP_SCALEROW) state_in = ST_ROW_WR;
            else if (op_ff == OP_ADDROWMUL) state_in = ST_ROW_RD2;
            else state_in = ST_DONE;
         end
         ST_MAG_E:    if (step_ff == 2'd1) state_in = ST_MAG_B;
         ST_MAG_B:    if (step_ff == 2'd1) state_in = ST_MAG_END;
         ST_MAG_END: begin
            if (op_ff == OP_INV && !acc_zero) state_in = ST_DIV_RE;
            else state_in = ST_DONE;
         end
         ST_DIV_RE:   if (div_done) state_in = ST_DIV_IM;
         ST_DIV_IM:   if (div_done) state_in = ST_DONE;
         ST_ROW_RD:   state_in = ST_ROW_CAP;
         ST_ROW_CAP:  state_in = ST_CMUL;
         ST_ROW_RD2:  state_in = ST_ROW_CAP2;
         ST_ROW_CAP2: state_in = ST_ROW_WR;
         ST_ROW_WR:   state_in = last_row_col ? ST_DONE : ST_ROW_RD;
         ST_SW_RDA:   state_in = ST_SW_RDB;
         ST_SW_RDB:   state_in = ST_SW_WR1;
         ST_SW_WR1:   state_in = ST_SW_WR2;
         ST_SW_WR2:   state_in = last_swap_col ? ST_DONE : ST_SW_RDA;
         ST_DONE:     if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:     state_in = ST_CLEAR;
      endcase
   end

   // datapath and unit controls
   always_comb begin
      rows_in    = rows_ff;
      cols_in    = cols_ff;
      op_in      = op_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      srow_in    = srow_ff;
      vre_in     = vre_ff;
      vim_in     = vim_ff;
      buf_re_in  = buf_re_ff;
      buf_im_in  = buf_im_ff;
      elem_re_in = elem_re_ff;
      elem_im_in = elem_im_ff;
      res_re_in  = res_re_ff;
      res_im_in  = res_im_ff;
      mag_in     = mag_ff;
      flag_in    = flag_ff;
      err_in     = err_ff;
      sat_in     = sat_ff;
      step_in    = step_ff;
      cnt_in     = cnt_ff;
      clr_in     = clr_ff;
      rsp_load   = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = ea;
      ram_wdata  = {buf_re_ff, buf_im_ff};
      ram_re     = 1'b0;
      ram_raddr  = ea;
      mul_ctrl   = '0;
      mul_a      = buf_re_ff;
      mul_b      = elem_re_ff;
      div_start  = 1'b0;
      div_num    = buf_re_ff[31] ? 32'(-buf_re_ff) : 32'(buf_re_ff);
      div_den    = acc[63:0];
      c_re       = '0;
      c_im       = '0;
      elem_op    = 1'b0;

      if (csr_valid) begin
         case (csr_index)
            REG_ROWS: rows_in = csr_data;
            REG_COLS: cols_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_accept) begin
               op_in   = req_tuser;
               row_in  = req_tdata[2:0];
               col_in  = req_tdata[5:3];
               srow_in = req_tdata[8:6];
               vre_in  = req_tdata[40:9];
               vim_in  = req_tdata[72:41];
               flag_in = 1'b0;
               sat_in  = 1'b0;
               step_in = '0;
               cnt_in  = '0;
               err_in  = ERR_OK;
               elem_op = req_tuser inside {[OP_LOAD:OP_ADD], [OP_MAXABS:OP_ISZERO]};
               if (elem_op && (4'(req_tdata[2:0]) >= nr || 4'(req_tdata[5:3]) >= nc))
                  err_in = ERR_RANGE;
               if ((req_tuser inside {[OP_SWAPROWS:OP_ADDROWMUL]})
                   && 4'(req_tdata[2:0]) >= nr)
                  err_in = ERR_RANGE;
               if ((req_tuser inside {OP_SWAPROWS, OP_ADDROWMUL})
                   && 4'(req_tdata[8:6]) >= nr)
                  err_in = ERR_RANGE;
            end
         end
         ST_DECODE: begin
            if (err_ff == ERR_OK) begin
               case (op_ff)
                  OP_ZERO: begin
                     buf_re_in = '0;
                     buf_im_in = '0;
                  end
                  OP_UNIT: begin
                     buf_re_in = Q_ONE;
                     buf_im_in = '0;
                  end
                  OP_SETBUF: begin
                     buf_re_in = vre_ff;
                     buf_im_in = vim_ff;
                  end
                  OP_NEG: begin
                     c_re      = neg_clamp(buf_re_ff);
                     c_im      = neg_clamp(buf_im_ff);
                     buf_re_in = c_re.val;
                     buf_im_in = c_im.val;
                     sat_in    = c_re.sat | c_im.sat;
                  end
                  OP_LOAD, OP_STORE, OP_SWAP, OP_MUL, OP_ADD,
                  OP_MAXABS, OP_ISUNIT, OP_ISZERO: begin
                     ram_re    = 1'b1;
                     ram_raddr = ea;
                  end
                  default: ;
               endcase
               step_in = '0;
            end
         end
         ST_ELEM: begin
            elem_re_in = rd_re;
            elem_im_in = rd_im;
            step_in    = '0;
            case (op_ff)
               OP_LOAD: begin
                  buf_re_in = rd_re;
                  buf_im_in = rd_im;
               end
               OP_STORE: ram_we = 1'b1;
               OP_SWAP: begin
                  ram_we    = 1'b1;
                  buf_re_in = rd_re;
                  buf_im_in = rd_im;
               end
               OP_ADD: begin
                  c_re      = add_clamp(buf_re_ff, rd_re);
                  c_im      = add_clamp(buf_im_ff, rd_im);
                  buf_re_in = c_re.val;
                  buf_im_in = c_im.val;
                  sat_in    = c_re.sat | c_im.sat;
               end
               OP_ISUNIT: flag_in = (rd_re == $signed(Q_ONE)) && (rd_im == 32'sd0);
               OP_ISZERO: flag_in = (rd_re == 32'sd0) && (rd_im == 32'sd0);
               default: ;
            endcase
         end
         ST_CMUL: begin
            // re = ar*br - ai*bi, im = ar*bi + ai*br
            mul_ctrl.en = 1'b1;
            step_in     = step_ff + 1'b1;
            case (step_ff)
               2'd0: begin
                  mul_ctrl.clr = 1'b1;
               end
               2'd1: begin
                  mul_a        = buf_im_ff;
                  mul_b        = elem_im_ff;
                  mul_ctrl.sub = 1'b1;
               end
               2'd2: begin
                  c_re         = rnd_clamp(acc);
                  res_re_in    = c_re.val;
                  sat_in       = sat_ff | c_re.sat;
                  mul_b        = elem_im_ff;
                  mul_ctrl.clr = 1'b1;
               end
               default: begin
                  mul_a = buf_im_ff;
               end
            endcase
         end
         ST_CMUL_END: begin
            c_im      = rnd_clamp(acc);
            res_im_in = c_im.val;
            sat_in    = sat_ff | c_im.sat;
            if (op_ff == OP_MUL) begin
               buf_re_in = res_re_ff;
               buf_im_in = c_im.val;
            end
         end
         ST_MAG_E: begin
            mul_ctrl.en  = 1'b1;
            mul_ctrl.clr = (step_ff == 2'd0);
            mul_a        = (step_ff == 2'd0) ? elem_re_ff : elem_im_ff;
            mul_b        = mul_a;
            step_in      = (step_ff == 2'd1) ? 2'd0 : step_ff + 1'b1;
         end
         ST_MAG_B: begin
            if (step_ff == 2'd0) mag_in = acc[63:0];
            mul_ctrl.en  = 1'b1;
            mul_ctrl.clr = (step_ff == 2'd0);
            mul_a        = (step_ff == 2'd0) ? buf_re_ff : buf_im_ff;
            mul_b        = mul_a;
            step_in      = (step_ff == 2'd1) ? 2'd0 : step_ff + 1'b1;
         end
         ST_MAG_END: begin
            if (op_ff == OP_MAXABS) begin
               // element wins only when strictly larger
               if (mag_ff > acc[63:0]) begin
                  buf_re_in = elem_re_ff;
                  buf_im_in = elem_im_ff;
                  flag_in   = 1'b1;
               end
            end else if (acc_zero) begin
               err_in = ERR_DIV0;
            end else begin
               mag_in    = acc[63:0];
               div_start = 1'b1;
            end
         end
         ST_DIV_RE: begin
            if (div_done) begin
               c_re      = div_fix(div_quo, buf_re_ff[31]);
               res_re_in = c_re.val;
               sat_in    = sat_ff | c_re.sat;
               div_start = 1'b1;
               div_num   = buf_im_ff[31] ? 32'(-buf_im_ff) : 32'(buf_im_ff);
               div_den   = mag_ff;
            end
         end
         ST_DIV_IM: begin
            if (div_done) begin
               // conjugate: imaginary part flips sign
               c_im      = div_fix(div_quo, !buf_im_ff[31] && (buf_im_ff != 32'sd0));
               buf_re_in = res_re_ff;
               buf_im_in = c_im.val;
               sat_in    = sat_ff | c_im.sat;
            end
         end
         ST_ROW_RD: begin
            ram_re    = 1'b1;
            ram_raddr = (op_ff == OP_ADDROWMUL) ? sa_c : ra_c;
         end
         ST_ROW_CAP: begin
            elem_re_in = rd_re;
            elem_im_in = rd_im;
            step_in    = '0;
         end
         ST_ROW_RD2: begin
            ram_re    = 1'b1;
            ram_raddr = ra_c;
         end
         ST_ROW_CAP2: begin
            elem_re_in = rd_re;
            elem_im_in = rd_im;
         end
         ST_ROW_WR: begin
            ram_we    = 1'b1;
            ram_waddr = ra_c;
            if (op_ff == OP_ADDROWMUL) begin
               c_re      = add_clamp(elem_re_ff, res_re_ff);
               c_im      = add_clamp(elem_im_ff, res_im_ff);
               ram_wdata = {c_re.val, c_im.val};
               sat_in    = sat_ff | c_re.sat | c_im.sat;
            end else begin
               ram_wdata = {res_re_ff, res_im_ff};
            end
            cnt_in = cnt_ff + 1'b1;
         end
         ST_SW_RDA: begin
            ram_re    = 1'b1;
            ram_raddr = ra_c;
         end
         ST_SW_RDB: begin
            elem_re_in = rd_re;
            elem_im_in = rd_im;
            ram_re     = 1'b1;
            ram_raddr  = sa_c;
         end
         ST_SW_WR1: begin
            ram_we    = 1'b1;
            ram_waddr = ra_c;
            ram_wdata = ram_rdata;
         end
         ST_SW_WR2: begin
            ram_we    = 1'b1;
            ram_waddr = sa_c;
            ram_wdata = {elem_re_ff, elem_im_ff};
            cnt_in    = cnt_ff + 1'b1;
         end
         ST_DONE: begin
            rsp_load = !rsp_valid_ff || rsp_tready;
         end
         default: ;
      endcase

      rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rsp_data_in  = rsp_load ? {4'b0, sat_ff, err_ff, flag_ff, buf_im_ff, buf_re_ff}
                              : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rows_ff      <= 4'd8;
         cols_ff      <= 4'd8;
         buf_re_ff    <= '0;
         buf_im_ff    <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         buf_re_ff    <= buf_re_in;
         buf_im_ff    <= buf_im_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
      end
      op_ff      <= op_in;
      row_ff     <= row_in;
      col_ff     <= col_in;
      srow_ff    <= srow_in;
      vre_ff     <= vre_in;
      vim_ff     <= vim_in;
      elem_re_ff <= elem_re_in;
      elem_im_ff <= elem_im_in;
      res_re_ff  <= res_re_in;
      res_im_ff  <= res_im_in;
      mag_ff     <= mag_in;
      flag_ff    <= flag_in;
      err_ff     <= err_in;
      sat_ff     <= sat_in;
      rsp_data_ff <= rsp_data_in;
   end

   // divide-by-zero code only comes out of an inversion
   `CMROE_ASSERT(a_div0_only_inv, clock, reset, rsp_load && err_ff == ERR_DIV0 |-> op_ff == OP_INV, "divide error on a non-invert op")
   // flag is set only by maxabs and the two element tests
   `CMROE_ASSERT(a_flag_ops, clock, reset, rsp_load && flag_ff |-> (op_ff == OP_MAXABS || op_ff == OP_ISUNIT || op_ff == OP_ISZERO), "flag set by wrong op")
   // an index error goes straight to the response without touching state
   `CMROE_ASSERT(a_err_skips, clock, reset, state_ff == ST_DECODE && err_ff != ERR_OK |=> state_ff == ST_DONE, "index error did not skip the op")
   // matrix is never written while waiting for a request
   `CMROE_ASSERT_ALWAYS(a_idle_no_write, clock, state_ff == ST_IDLE |-> !ram_we, "RAM write while idle")

endmodule

>>> hdl/cmroe_ram.sv
// Generic single write port RAM with registered read.
module cmroe_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/cmroe_mul.sv
// Shared 32x32 signed multiply-accumulate unit.
module cmroe_mul
   import cmroe_pkg::*;
(
   input  logic                clock,
   input  mul_ctrl_type        ctrl,
   input  logic signed [31:0]  a,
   input  logic signed [31:0]  b,
   output logic signed [65:0]  acc
);

   logic signed [63:0] prod;
   logic signed [65:0] base;
   logic signed [65:0] acc_in;
   logic signed [65:0] acc_ff;

   always_comb begin
      prod   = a * b;
      base   = ctrl.clr ? 66'sd0 : acc_ff;
      acc_in = ctrl.sub ? base - 66'(prod) : base + 66'(prod);
   end

   always_ff @(posedge clock) begin
      if (ctrl.en) acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

>>> hdl/cmroe_div.sv
// Restoring divider: ((num << 32) + den/2) / den, one quotient bit per cycle.
module cmroe_div
   import cmroe_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [31:0]      num,
   input  logic [63:0]      den,
   output logic             done,
   output logic [QUO_W-1:0] quo
);

   localparam int CNT_W = $clog2(QUO_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [63:0]      rem_ff, rem_in;
   logic [63:0]      den_ff, den_in;
   logic [QUO_W-1:0] low_ff, low_in;
   logic [QUO_W-1:0] q_ff, q_in;
   logic [64:0]      nsum;
   logic [64:0]      trial;
   logic             fits;

   always_comb begin
      nsum    = {1'b0, num, 32'b0} + {2'b0, den[63:1]};
      trial   = {rem_ff, low_ff[QUO_W-1]};
      fits    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      low_in  = low_ff;
      q_in    = q_ff;
      if (busy_ff) begin
         rem_in = fits ? 64'(trial - {1'b0, den_ff}) : trial[63:0];
         low_in = {low_ff[QUO_W-2:0], 1'b0};
         q_in   = {q_ff[QUO_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(QUO_W);
         rem_in  = 64'(nsum[64:QUO_W]);
         low_in  = nsum[QUO_W-1:0];
         den_in  = den;
         q_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      low_ff <= low_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quo  = q_ff;

endmodule

>>> test/complex_matrix_row_op_engine_test.sv
// Self-checking testbench for the complex matrix row operation engine.
`timescale 1ns / 100ps

module complex_matrix_row_op_engine_test;
   import cmroe_pkg::*;

   localparam int NROW = 8;
   localparam int NCOL = 8;

   typedef struct {
      logic [31:0] re;
      logic [31:0] im;
   } cnum_type;

   typedef struct {
      logic [4:0]  op;
      logic [2:0]  row;
      logic [2:0]  col;
      logic [2:0]  src;
      logic [31:0] vre;
      logic [31:0] vim;
      logic        fixed;   // expected result typed in the table
      logic [31:0] ere;
      logic [31:0] eim;
      logic        eflag;
      logic [1:0]  eerr;
      logic        esat;
   } stim_type;

   typedef struct {
      logic [31:0] re;
      logic [31:0] im;
      logic        flag;
      logic [1:0]  err;
      logic        sat;
   } result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic [4:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = '0;
   logic [3:0]  csr_data = '0;

   // shadow copy of the engine state
   cnum_type    mat [NROW*NCOL];
   cnum_type    buf_q;
   int unsigned rows_cfg, cols_cfg;

   result_type  expected_q[$];
   int          errors = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;

   always #10 clock = ~clock;

   complex_matrix_row_op_engine i_dut (.*);

   // ---------------------------------------------------------------------
   // arithmetic of the engine, Q16.16
   // ---------------------------------------------------------------------
   function automatic logic [31:0] clamp(input longint v, inout logic sat);
      if (v > 64'sd2147483647) begin sat = 1'b1; return 32'h7FFF_FFFF; end
      if (v < -64'sd2147483648) begin sat = 1'b1; return 32'h8000_0000; end
      return v[31:0];
   endfunction

   // round to nearest, ties up: arithmetic shift does the floor
   function automatic longint round16(input longint x);
      return (x + 64'sd32768) >>> 16;
   endfunction

   function automatic cnum_type cmul(input cnum_type a, input cnum_type b, inout logic sat);
      longint ar, ai, br, bi;
      cnum_type r;
      ar = longint'($signed(a.re)); ai = longint'($signed(a.im));
      br = longint'($signed(b.re)); bi = longint'($signed(b.im));
      r.re = clamp(round16(ar*br - ai*bi), sat);
      r.im = clamp(round16(ar*bi + ai*br), sat);
      return r;
   endfunction

   function automatic cnum_type cadd(input cnum_type a, input cnum_type b, inout logic sat);
      cnum_type r;
      r.re = clamp(longint'($signed(a.re)) + longint'($signed(b.re)), sat);
      r.im = clamp(longint'($signed(a.im)) + longint'($signed(b.im)), sat);
      return r;
   endfunction

   function automatic logic [63:0] mag2(input cnum_type a);
      longint r, i;
      r = longint'($signed(a.re)); i = longint'($signed(a.im));
      return 64'(r*r) + 64'(i*i);
   endfunction

   // (|n| << 32) / d, rounded half away from zero, signed and clamped
   function automatic logic [31:0] div_part(input logic [31:0] n, input logic neg,
                                            input logic [63:0] d, inout logic sat);
      logic [127:0] un, q;
      un = $signed(n) < 0 ? 128'(-longint'($signed(n))) : 128'(n);
      q = ((un << 32) + 128'(d >> 1)) / 128'(d);
      if (neg) begin
         if (q > 128'h8000_0000) begin sat = 1'b1; return 32'h8000_0000; end
         return 32'(-q);
      end
      if (q > 128'h7FFF_FFFF) begin sat = 1'b1; return 32'h7FFF_FFFF; end
      return q[31:0];
   endfunction

   // expected response of one request; updates the shadow state
   function automatic result_type engine_step(input stim_type s);
      result_type r;
      int unsigned nr, nc, idx;
      logic elem;
      logic [63:0] d;
      cnum_type t;
      r = '{default: '0};
      nr = rows_cfg > NROW ? NROW : rows_cfg;
      nc = cols_cfg > NCOL ? NCOL : cols_cfg;
      elem = (s.op >= OP_LOAD && s.op <= OP_ADD) || (s.op >= OP_MAXABS && s.op <= OP_ISZERO);
      if (elem && (s.row >= nr || s.col >= nc)) r.err = ERR_RANGE;
      if ((s.op == OP_SWAPROWS || s.op == OP_SCALEROW || s.op == OP_ADDROWMUL) && s.row >= nr)
         r.err = ERR_RANGE;
      if ((s.op == OP_SWAPROWS || s.op == OP_ADDROWMUL) && s.src >= nr) r.err = ERR_RANGE;
      idx = s.row * NCOL + s.col;
      if (r.err == ERR_OK) begin
         case (s.op)
            OP_ZERO:   buf_q = '{32'd0, 32'd0};
            OP_UNIT:   buf_q = '{Q_ONE, 32'd0};
            OP_SETBUF: buf_q = '{s.vre, s.vim};
            OP_LOAD:   buf_q = mat[idx];
            OP_STORE:  mat[idx] = buf_q;
            OP_SWAP: begin
               t = mat[idx]; mat[idx] = buf_q; buf_q = t;
            end
            OP_MUL:    buf_q = cmul(buf_q, mat[idx], r.sat);
            OP_ADD:    buf_q = cadd(buf_q, mat[idx], r.sat);
            OP_NEG: begin
               buf_q.re = clamp(-longint'($signed(buf_q.re)), r.sat);
               buf_q.im = clamp(-longint'($signed(buf_q.im)), r.sat);
            end
            OP_INV: begin
               d = mag2(buf_q);
               if (d == 0) r.err = ERR_DIV0;
               else begin
                  t.re = div_part(buf_q.re, $signed(buf_q.re) < 0, d, r.sat);
                  t.im = div_part(buf_q.im, $signed(buf_q.im) > 0, d, r.sat);
                  buf_q = t;
               end
            end
            OP_MAXABS:
               if (mag2(mat[idx]) > mag2(buf_q)) begin
                  buf_q = mat[idx]; r.flag = 1'b1;
               end
            OP_ISUNIT: r.flag = (mat[idx].re == Q_ONE && mat[idx].im == 0);
            OP_ISZERO: r.flag = (mat[idx].re == 0 && mat[idx].im == 0);
            OP_SWAPROWS:
               for (int c = 0; c < NCOL; c++) begin
                  t = mat[s.row*NCOL+c];
                  mat[s.row*NCOL+c] = mat[s.src*NCOL+c];
                  mat[s.src*NCOL+c] = t;
               end
            OP_SCALEROW:
               for (int c = 0; c < nc; c++)
                  mat[s.row*NCOL+c] = cmul(mat[s.row*NCOL+c], buf_q, r.sat);
            OP_ADDROWMUL:
               for (int c = 0; c < nc; c++) begin
                  t = cmul(buf_q, mat[s.src*NCOL+c], r.sat);
                  mat[s.row*NCOL+c] = cadd(mat[s.row*NCOL+c], t, r.sat);
               end
            default: ;
         endcase
      end
      r.re = buf_q.re;
      r.im = buf_q.im;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // ---------------------------------------------------------------------
   // stimulus side
   // ---------------------------------------------------------------------
   task automatic send_beat(input stim_type s);
      result_type r;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) @(posedge clock);
      r = engine_step(s);
      if (s.fixed && (r.re != s.ere || r.im != s.eim || r.flag != s.eflag ||
                      r.err != s.eerr || r.sat != s.esat)) begin
         // table row disagrees with the predictor: trust the table
         report_mismatch("table vs predictor", {r.flag, r.err, r.sat}, {s.eflag, s.eerr, s.esat});
         r = '{s.ere, s.eim, s.eflag, s.eerr, s.esat};
      end
      req_tvalid <= 1'b1;
      req_tuser  <= s.op;
      req_tdata  <= {7'd0, s.vim, s.vre, s.src, s.col, s.row};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_q.push_back(r);
      req_tvalid <= 1'b0;
      // engine is busy for at least this cycle anyway
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [0:0] idx, input logic [3:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == REG_ROWS) rows_cfg = val; else cols_cfg = val;
      @(posedge clock);
   endtask

   // wait for all responses, then let the longest op (row walk) drain
   task automatic drain;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_q;
      case ($urandom_range(5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom;
         default: return 32'($signed($urandom_range(262143)) - 131072) <<< $urandom_range(4);
      endcase
   endfunction

   function automatic stim_type rand_item;
      stim_type s;
      s = '{default: '0};
      s.op  = ($urandom_range(99) < 3) ? 5'($urandom_range(31, 17)) : 5'($urandom_range(16));
      s.row = 3'($urandom); s.col = 3'($urandom); s.src = 3'($urandom);
      s.vre = rand_q(); s.vim = rand_q();
      return s;
   endfunction

   function automatic stim_type mk(input logic [4:0] op, input int row, input int col,
                                   input int src, input logic [31:0] vre,
                                   input logic [31:0] vim);
      return '{op, 3'(row), 3'(col), 3'(src), vre, vim, 1'b0, 32'd0, 32'd0, 1'b0, 2'd0, 1'b0};
   endfunction

   function automatic stim_type mkx(input logic [4:0] op, input int row, input int col,
                                    input logic [31:0] vre, input logic [31:0] vim,
                                    input logic [31:0] ere, input logic [31:0] eim,
                                    input logic fl, input logic [1:0] er, input logic st);
      return '{op, 3'(row), 3'(col), 3'd0, vre, vim, 1'b1, ere, eim, fl, er, st};
   endfunction

   // ---------------------------------------------------------------------
   // response side
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      result_type want;
      if (reset) rsp_tready <= 1'b0;
      else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) report_mismatch("unexpected beat", rsp_tdata[31:0], 0);
            else begin
               want = expected_q.pop_front();
               if (rsp_tdata[31:0] != want.re) report_mismatch("buffer_re", rsp_tdata[31:0], want.re);
               if (rsp_tdata[63:32] != want.im) report_mismatch("buffer_im", rsp_tdata[63:32], want.im);
               if (rsp_tdata[64] != want.flag) report_mismatch("flag", rsp_tdata[64], want.flag);
               if (rsp_tdata[66:65] != want.err) report_mismatch("error", rsp_tdata[66:65], want.err);
               if (rsp_tdata[67] != want.sat) report_mismatch("saturated", rsp_tdata[67], want.sat);
            end
         end
         rsp_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      stim_type table_q[$];
      int    phase_idle [4] = '{0, 81, 0, 31};
      int    phase_stall[4] = '{0, 0, 81, 31};
      for (int i = 0; i < NROW*NCOL; i++) mat[i] = '{0, 0};
      buf_q = '{0, 0};
      rows_cfg = 8; cols_cfg = 8;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: reset state, extremes, every op but OP_ZERO, the divide error
      table_q = '{
         mkx(OP_READBUF, 0, 0, 0, 0, 0, 0, 1'b0, ERR_OK, 1'b0),
         mkx(OP_ISZERO, 7, 7, 0, 0, 0, 0, 1'b1, ERR_OK, 1'b0),
         mkx(OP_INV, 0, 0, 0, 0, 0, 0, 1'b0, ERR_DIV0, 1'b0),
         mkx(OP_UNIT, 0, 0, 0, 0, Q_ONE, 0, 1'b0, ERR_OK, 1'b0),
         mkx(OP_STORE, 3, 4, 0, 0, Q_ONE, 0, 1'b0, ERR_OK, 1'b0),
         mkx(OP_ISUNIT, 3, 4, 0, 0, Q_ONE, 0, 1'b1, ERR_OK, 1'b0),
         mkx(OP_SETBUF, 0, 0, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 1'b0, ERR_OK, 1'b0),
         mkx(OP_NEG, 0, 0, 0, 0, Q_MAX, 32'h8000_0001, 1'b0, ERR_OK, 1'b1),
         mk(OP_STORE, 7, 7, 0, 0, 0),
         mk(OP_ADD, 7, 7, 0, 0, 0),
         mk(OP_MUL, 7, 7, 0, 0, 0),
         mk(OP_SETBUF, 0, 0, 0, 32'h0002_0000, 32'hFFFF_0000),
         mk(OP_INV, 0, 0, 0, 0, 0),
         mk(OP_SWAP, 3, 4, 0, 0, 0),
         mk(OP_LOAD, 7, 7, 0, 0, 0),
         mk(OP_MAXABS, 3, 4, 0, 0, 0),
         mk(OP_MAXABS, 0, 0, 0, 0, 0),
         mk(OP_SCALEROW, 7, 0, 0, 0, 0),
         mk(OP_ADDROWMUL, 3, 0, 7, 0, 0),
         mk(OP_ADDROWMUL, 3, 0, 3, 0, 0),
         mk(OP_SWAPROWS, 0, 0, 7, 0, 0),
         mk(OP_SETBUF, 0, 0, 0, 32'h0000_0001, 32'h0000_0000),
         mk(OP_INV, 0, 0, 0, 0, 0),
         mk(5'd31, 0, 0, 0, 0, 0)
      };
      foreach (table_q[i]) send_beat(table_q[i]);
      drain();

      // small matrix: index errors, typed in
      write_reg(REG_ROWS, 4'd1);
      write_reg(REG_COLS, 4'd1);
      send_beat(mkx(OP_LOAD, 1, 0, 0, 0, buf_q.re, buf_q.im, 1'b0, ERR_RANGE, 1'b0));
      send_beat(mkx(OP_ISZERO, 0, 1, 0, 0, buf_q.re, buf_q.im, 1'b0, ERR_RANGE, 1'b0));
      drain();
      write_reg(REG_ROWS, 4'd0);
      send_beat(mkx(OP_SCALEROW, 0, 0, 0, 0, buf_q.re, buf_q.im, 1'b0, ERR_RANGE, 1'b0));
      drain();

      // random part: four idling phases, each under a few register settings
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = phase_idle[p];
         recv_stall_pct = phase_stall[p];
         for (int k = 0; k < 3; k++) begin
            write_reg(REG_ROWS, k == 0 ? 4'd15 : (k == 1 ? 4'd8 : 4'($urandom_range(1, 9))));
            write_reg(REG_COLS, k == 0 ? 4'd15 : (k == 1 ? 4'd1 : 4'($urandom_range(1, 9))));
            for (int n = 0; n < 100; n++) begin
               send_beat(rand_item());
               // pause the sender until the engine has caught up
               if (n == 50) while (expected_q.size() != 0) @(posedge clock);
            end
            drain();
         end
      end

      if (errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   // timeout from the worst case idle, busy and stall time per item, 1300 items
   initial begin
      #20ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule

>>> complex_matrix_row_op_engine.f
+incdir+hdl
hdl/cmroe_pkg.sv
hdl/cmroe_ram.sv
hdl/cmroe_mul.sv
hdl/cmroe_div.sv
hdl/complex_matrix_row_op_engine.sv
test/complex_matrix_row_op_engine_test.sv
